/* sv/assert_macros.svh */
// Assertion macros shared by the heightfield sampler RTL.
// Plain text macros only; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/hfts_pkg.sv */
// Package for the heightfield triangle sampler: sizes, codes and item types.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package hfts_pkg;

   // Map geometry and stored height width.
   localparam int MAP_DIM     = 256;
   localparam int HEIGHT_BITS = 16;
   localparam int IDX_BITS    = $clog2(MAP_DIM);
   localparam int MEM_DEPTH   = MAP_DIM * MAP_DIM;
   localparam int ADDR_BITS   = $clog2(MEM_DEPTH);

   // Field widths of the ports.
   localparam int COORD_BITS  = 8;
   localparam int LOAD_H_BITS = 16;
   localparam int QPOS_BITS   = 24;
   localparam int SIZE_BITS   = 9;
   localparam int RECIP_BITS  = 24;
   localparam int OUT_BITS    = 24;

   // Fixed-point layout of the scaled position and of the result.
   localparam int FRAC_BITS   = 12;
   localparam int FRAC_W      = FRAC_BITS + 1;
   localparam int PROD_BITS   = QPOS_BITS + RECIP_BITS;
   localparam int IP_BITS     = PROD_BITS - 2 * FRAC_BITS;
   localparam int OUT_FRAC    = 8;
   localparam int ROUND_SHIFT = 2 * FRAC_BITS - OUT_FRAC;
   localparam int ROUND_ADD   = 1 << (ROUND_SHIFT - 1);

   // Datapath widths of the interpolation, all derived from the height width.
   localparam int CORNER_BITS = HEIGHT_BITS + 2;
   localparam int DIFF_BITS   = HEIGHT_BITS + 3;
   localparam int XPROD_BITS  = DIFF_BITS + FRAC_W;
   localparam int TOP_BITS    = HEIGHT_BITS + 17;
   localparam int DLT_BITS    = TOP_BITS + 1;
   localparam int ZPROD_BITS  = DLT_BITS + FRAC_W;
   localparam int H_BITS      = TOP_BITS + FRAC_W + 2;

   localparam logic signed [OUT_BITS-1:0] OUT_MAX = {1'b0, {(OUT_BITS - 1){1'b1}}};
   localparam logic signed [OUT_BITS-1:0] OUT_MIN = {1'b1, {(OUT_BITS - 1){1'b0}}};

   // Queue between the front and the back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // Configuration port.
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 24;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAP_SIZE   = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GRID_RECIP = CSR_INDEX_BITS'(1);
   localparam logic [SIZE_BITS-1:0]  MAP_SIZE_RESET   = SIZE_BITS'(256);
   localparam logic [RECIP_BITS-1:0] GRID_RECIP_RESET = RECIP_BITS'(65536);

   // Item kinds.
   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   typedef struct packed {
      logic                          kind;
      logic [COORD_BITS-1:0]         load_col;
      logic [COORD_BITS-1:0]         load_row;
      logic signed [LOAD_H_BITS-1:0] load_height;
      logic signed [QPOS_BITS-1:0]   query_x;
      logic signed [QPOS_BITS-1:0]   query_z;
   } hfts_req_type;

   typedef struct packed {
      logic signed [OUT_BITS-1:0] height_out;
      logic                       saturated;
   } hfts_rsp_type;

   // Classified work for the back. A load uses addr_nw and height only.
   typedef struct packed {
      logic                          is_query;
      logic [ADDR_BITS-1:0]          addr_nw;
      logic [ADDR_BITS-1:0]          addr_se;
      logic [ADDR_BITS-1:0]          addr_alt;
      logic                          tri_ne;
      logic signed [FRAC_W-1:0]      xf;
      logic signed [FRAC_W-1:0]      zf;
      logic signed [HEIGHT_BITS-1:0] height;
   } hfts_job_type;

   typedef struct packed {
      logic valid;
      logic full;
   } hfts_qstat_type;

endpackage

`default_nettype wire

/* sv/hfts_front.sv */
// Front of the heightfield sampler: configuration registers, input stage,
// position scaling and cell classification. Uses hfts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hfts_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  hfts_pkg::hfts_req_type                req_data,
   input  logic                                  csr_we,
   input  logic [hfts_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [hfts_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   output logic                                  job_push,
   output hfts_pkg::hfts_job_type                job_data,
   input  hfts_pkg::hfts_qstat_type              qstat
);
   import hfts_pkg::*;

   logic [SIZE_BITS-1:0]  map_size_ff;
   logic [RECIP_BITS-1:0] grid_recip_ff;

   logic                  s1_valid_ff;
   logic                  s1_valid_in;
   hfts_req_type          s1_req_ff;
   logic [PROD_BITS-1:0]  s1_prod_x_ff;
   logic [PROD_BITS-1:0]  s1_prod_z_ff;

   logic                  req_accept;
   logic                  s1_leave;
   logic                  keep;
   logic                  in_grid;
   logic                  is_query;
   logic                  neg_x;
   logic                  neg_z;
   logic [QPOS_BITS-1:0]  mag_x;
   logic [QPOS_BITS-1:0]  mag_z;
   logic [PROD_BITS-1:0]  prod_x;
   logic [PROD_BITS-1:0]  prod_z;
   logic [IDX_BITS-1:0]   limit;
   logic [IDX_BITS-1:0]   cell_x;
   logic [IDX_BITS-1:0]   cell_z;
   logic signed [FRAC_W-1:0] frac_x;
   logic signed [FRAC_W-1:0] frac_z;
   logic                  tri_ne;
   logic [ADDR_BITS-1:0]  base_addr;
   logic [ADDR_BITS-1:0]  load_addr;

   // Magnitude of a signed position; the most negative value maps to 2^23.
   function automatic logic [QPOS_BITS-1:0] magnitude(input logic signed [QPOS_BITS-1:0] v);
      return $unsigned(v[QPOS_BITS-1] ? -v : v);
   endfunction

   // Integer cell of a scaled coordinate. A negative position truncates to a
   // value at or below zero, so it always clamps to cell zero.
   function automatic logic [IDX_BITS-1:0] cell_of(input logic [PROD_BITS-1:0] prod,
                                                   input logic neg,
                                                   input logic [IDX_BITS-1:0] lim);
      logic [IP_BITS-1:0] ip;
      ip = prod[PROD_BITS-1 -: IP_BITS];
      priority if (neg) begin
         return '0;
      end else if (ip > IP_BITS'(lim)) begin
         return lim;
      end else begin
         return ip[IDX_BITS-1:0];
      end
   endfunction

   // Signed fraction of a scaled coordinate, taking the sign of the position.
   function automatic logic signed [FRAC_W-1:0] frac_of(input logic [PROD_BITS-1:0] prod,
                                                        input logic neg);
      logic signed [FRAC_W-1:0] f;
      f = $signed({1'b0, prod[2*FRAC_BITS-1 -: FRAC_BITS]});
      return neg ? -f : f;
   endfunction

   // Configuration registers; the user must write them only while the block is idle, the block does not enforce it.
   always_ff @(posedge clock) begin
      if (reset) begin
         map_size_ff   <= MAP_SIZE_RESET;
         grid_recip_ff <= GRID_RECIP_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MAP_SIZE:   map_size_ff   <= csr_wdata[SIZE_BITS-1:0];
            CSR_GRID_RECIP: grid_recip_ff <= csr_wdata[RECIP_BITS-1:0];
         endcase
      end
   end

   // Scale both coordinates by the grid reciprocal as the item comes in.
   always_comb begin
      mag_x  = magnitude(req_data.query_x);
      mag_z  = magnitude(req_data.query_z);
      prod_x = PROD_BITS'(mag_x) * PROD_BITS'(grid_recip_ff);
      prod_z = PROD_BITS'(mag_z) * PROD_BITS'(grid_recip_ff);
   end

   // Highest usable cell index: the map size saturated to 2..MAP_DIM, minus two.
   always_comb begin
      priority if (map_size_ff < SIZE_BITS'(2)) begin
         limit = '0;
      end else if (32'(map_size_ff) > MAP_DIM) begin
         limit = IDX_BITS'(MAP_DIM - 2);
      end else begin
         limit = IDX_BITS'(map_size_ff - SIZE_BITS'(2));
      end
   end

   // Classify the held item: cell, fractions, triangle and memory addresses.
   always_comb begin
      is_query  = (s1_req_ff.kind == KIND_QUERY);
      neg_x     = s1_req_ff.query_x[QPOS_BITS-1];
      neg_z     = s1_req_ff.query_z[QPOS_BITS-1];
      cell_x    = cell_of(s1_prod_x_ff, neg_x, limit);
      cell_z    = cell_of(s1_prod_z_ff, neg_z, limit);
      frac_x    = frac_of(s1_prod_x_ff, neg_x);
      frac_z    = frac_of(s1_prod_z_ff, neg_z);
      tri_ne    = (frac_z <= frac_x);
      base_addr = ADDR_BITS'(int'(cell_z) * MAP_DIM + int'(cell_x));
      load_addr = ADDR_BITS'(int'(s1_req_ff.load_row) * MAP_DIM + int'(s1_req_ff.load_col));
      in_grid   = (int'(s1_req_ff.load_col) < MAP_DIM) && (int'(s1_req_ff.load_row) < MAP_DIM);

      job_data.is_query = is_query;
      job_data.addr_nw  = is_query ? base_addr : load_addr;
      job_data.addr_se  = base_addr + ADDR_BITS'(MAP_DIM + 1);
      job_data.addr_alt = tri_ne ? base_addr + ADDR_BITS'(1) : base_addr + ADDR_BITS'(MAP_DIM);
      job_data.tri_ne   = tri_ne;
      job_data.xf       = frac_x;
      job_data.zf       = frac_z;
      job_data.height   = HEIGHT_BITS'(s1_req_ff.load_height);
   end

   // A load outside the grid is dropped here and never reaches the queue.
   always_comb begin
      keep        = is_query || in_grid;
      job_push    = s1_valid_ff && keep && !qstat.full;
      s1_leave    = s1_valid_ff && (!qstat.full || !keep);
      req_stall   = s1_valid_ff && !s1_leave;
      req_accept  = req_valid && !req_stall;
      s1_valid_in = req_accept || req_stall;
   end

   // Input stage register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (req_accept) begin
         s1_req_ff    <= req_data;
         s1_prod_x_ff <= prod_x;
         s1_prod_z_ff <= prod_z;
      end
   end

endmodule

`default_nettype wire

/* sv/hfts_fifo.sv */
// Short queue of classified items between the front and the back.
// Uses hfts_pkg for the item type and the queue depth.
`timescale 1ns / 1ps
`default_nettype none

module hfts_fifo (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  hfts_pkg::hfts_job_type    push_data,
   input  logic                      pop,
   output hfts_pkg::hfts_job_type    head,
   output hfts_pkg::hfts_qstat_type  qstat
);
   import hfts_pkg::*;

   hfts_job_type         slot_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff;
   logic [QPTR_BITS-1:0] rd_ptr_ff;
   logic [QCNT_BITS-1:0] count_ff;
   logic [QCNT_BITS-1:0] count_in;

   function automatic logic [QPTR_BITS-1:0] next_ptr(input logic [QPTR_BITS-1:0] p);
      return (p == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_BITS'(1);
   endfunction

   assign head        = slot_ff[rd_ptr_ff];
   assign qstat.valid = (count_ff != '0);
   assign qstat.full  = (count_ff == QCNT_BITS'(QUEUE_DEPTH));

   // Occupancy follows pushes and pops.
   always_comb begin
      unique case ({push, pop})
         2'b10:   count_in = count_ff + QCNT_BITS'(1);
         2'b01:   count_in = count_ff - QCNT_BITS'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

/* sv/hfts_back.sv */
// Back of the heightfield sampler: height memory, corner read sequencer,
// interpolation pipeline and output register. Uses hfts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hfts_back (
   input  logic                      clock,
   input  logic                      reset,
   input  hfts_pkg::hfts_job_type    head,
   input  hfts_pkg::hfts_qstat_type  qstat,
   output logic                      job_pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output hfts_pkg::hfts_rsp_type    rsp_data
);
   import hfts_pkg::*;

   typedef enum logic [1:0] {
      PH_NW,
      PH_SE,
      PH_ALT
   } phase_type;

   logic signed [HEIGHT_BITS-1:0] height_mem [MEM_DEPTH];
   logic signed [HEIGHT_BITS-1:0] rd_data_ff;

   phase_type                 phase_ff;
   phase_type                 phase_in;
   logic                      iss_valid_ff;
   phase_type                 iss_phase_ff;
   logic                      iss_tri_ff;
   logic signed [FRAC_W-1:0]  iss_xf_ff;
   logic signed [FRAC_W-1:0]  iss_zf_ff;
   logic signed [HEIGHT_BITS-1:0] nw_ff;
   logic signed [HEIGHT_BITS-1:0] se_ff;

   logic                      a_valid_ff;
   logic                      a_valid_in;
   logic signed [HEIGHT_BITS-1:0] a_nw_ff;
   logic signed [CORNER_BITS-1:0] a_sw_ff;
   logic signed [CORNER_BITS-1:0] a_sw_in;
   logic signed [DIFF_BITS-1:0]   a_dn_ff;
   logic signed [DIFF_BITS-1:0]   a_dn_in;
   logic signed [DIFF_BITS-1:0]   a_ds_ff;
   logic signed [DIFF_BITS-1:0]   a_ds_in;
   logic signed [FRAC_W-1:0]  a_xf_ff;
   logic signed [FRAC_W-1:0]  a_zf_ff;

   logic                      b_valid_ff;
   logic signed [TOP_BITS-1:0] b_top_ff;
   logic signed [TOP_BITS-1:0] b_top_in;
   logic signed [TOP_BITS-1:0] b_bot_ff;
   logic signed [TOP_BITS-1:0] b_bot_in;
   logic signed [FRAC_W-1:0]  b_zf_ff;

   logic                      c_valid_ff;
   logic signed [H_BITS-1:0]  c_h_ff;
   logic signed [H_BITS-1:0]  c_h_in;

   logic                      rsp_valid_ff;
   hfts_rsp_type              rsp_data_ff;
   hfts_rsp_type              rsp_data_in;

   logic                      en;
   logic                      head_query;
   logic                      head_load;
   logic                      rd_en;
   logic                      wr_en;
   logic [ADDR_BITS-1:0]      rd_addr;
   logic signed [CORNER_BITS-1:0] syn;
   logic signed [CORNER_BITS-1:0] ne_c;
   logic signed [XPROD_BITS-1:0]  xp_n;
   logic signed [XPROD_BITS-1:0]  xp_s;
   logic signed [DLT_BITS-1:0]    dlt;
   logic signed [ZPROD_BITS-1:0]  zp;
   logic signed [H_BITS:0]        hsum;
   logic signed [H_BITS:0]        hr;
   logic                      sat_hi;
   logic                      sat_lo;

   // The whole back advances together unless a result waits at the output.
   assign en         = !(rsp_valid_ff && rsp_stall);
   assign head_query = qstat.valid && head.is_query;
   assign head_load  = qstat.valid && !head.is_query;
   assign rd_en      = en && head_query;
   assign wr_en      = en && head_load;
   assign job_pop    = en && qstat.valid && (!head.is_query || phase_ff == PH_ALT);

   // A query reads its three corners one after another: nw, se, then alt; a load is a single write.
   always_comb begin
      phase_in = phase_ff;
      rd_addr  = head.addr_nw;
      unique case (phase_ff)
         PH_NW: begin
            rd_addr = head.addr_nw;
            if (head_query) begin
               phase_in = PH_SE;
            end
         end
         PH_SE: begin
            rd_addr = head.addr_se;
            if (head_query) begin
               phase_in = PH_ALT;
            end
         end
         PH_ALT: begin
            rd_addr = head.addr_alt;
            if (head_query) begin
               phase_in = PH_NW;
            end
         end
         default: begin
            rd_addr  = head.addr_nw;
            phase_in = PH_NW;
         end
      endcase
   end

   // Height memory: one write port for loads, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         height_mem[head.addr_nw] <= head.height;
      end
      if (rd_en) begin
         rd_data_ff <= height_mem[rd_addr];
      end
   end

   // Third corner arrives: synthesize the missing corner and form the slopes.
   always_comb begin
      a_valid_in = iss_valid_ff && (iss_phase_ff == PH_ALT);
      syn = CORNER_BITS'(nw_ff) + CORNER_BITS'(se_ff) - CORNER_BITS'(rd_data_ff);
      ne_c    = iss_tri_ff ? CORNER_BITS'(rd_data_ff) : syn;
      a_sw_in = iss_tri_ff ? syn : CORNER_BITS'(rd_data_ff);
      a_dn_in = DIFF_BITS'(ne_c) - DIFF_BITS'(nw_ff);
      a_ds_in = DIFF_BITS'(se_ff) - DIFF_BITS'(a_sw_in);
   end

   // Interpolate along x for the top and bottom edges.
   always_comb begin
      xp_n     = a_dn_ff * a_xf_ff;
      xp_s     = a_ds_ff * a_xf_ff;
      b_top_in = (TOP_BITS'(a_nw_ff) <<< FRAC_BITS) + TOP_BITS'(xp_n);
      b_bot_in = (TOP_BITS'(a_sw_ff) <<< FRAC_BITS) + TOP_BITS'(xp_s);
   end

   // Interpolate along z between the top and bottom edges.
   always_comb begin
      dlt    = DLT_BITS'(b_bot_ff) - DLT_BITS'(b_top_ff);
      zp     = dlt * b_zf_ff;
      c_h_in = (H_BITS'(b_top_ff) <<< FRAC_BITS) + H_BITS'(zp);
   end

   // Round to the output format and saturate.
   always_comb begin
      hsum   = (H_BITS + 1)'(c_h_ff) + (H_BITS + 1)'(ROUND_ADD);
      hr     = hsum >>> ROUND_SHIFT;
      sat_hi = hr > (H_BITS + 1)'(OUT_MAX);
      sat_lo = hr < (H_BITS + 1)'(OUT_MIN);
      priority if (sat_hi) begin
         rsp_data_in.height_out = OUT_MAX;
      end else if (sat_lo) begin
         rsp_data_in.height_out = OUT_MIN;
      end else begin
         rsp_data_in.height_out = hr[OUT_BITS-1:0];
      end
      rsp_data_in.saturated = sat_hi || sat_lo;
   end

   // Sequencer state, pipeline stages and the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_NW;
         iss_valid_ff <= 1'b0;
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         phase_ff     <= phase_in;
         iss_valid_ff <= head_query;
         a_valid_ff   <= a_valid_in;
         b_valid_ff   <= a_valid_ff;
         c_valid_ff   <= b_valid_ff;
         rsp_valid_ff <= c_valid_ff;
      end
      if (en) begin
         iss_phase_ff <= phase_ff;
         iss_tri_ff   <= head.tri_ne;
         iss_xf_ff    <= head.xf;
         iss_zf_ff    <= head.zf;
         if (iss_valid_ff && iss_phase_ff == PH_NW) begin
            nw_ff <= rd_data_ff;
         end
         if (iss_valid_ff && iss_phase_ff == PH_SE) begin
            se_ff <= rd_data_ff;
         end
         a_nw_ff     <= nw_ff;
         a_sw_ff     <= a_sw_in;
         a_dn_ff     <= a_dn_in;
         a_ds_ff     <= a_ds_in;
         a_xf_ff     <= iss_xf_ff;
         a_zf_ff     <= iss_zf_ff;
         b_top_ff    <= b_top_in;
         b_bot_ff    <= b_bot_in;
         b_zf_ff     <= a_zf_ff;
         c_h_ff      <= c_h_in;
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

/* sv/heightfield_triangle_sample.sv */
// Top level of the heightfield triangle sampler.
// Instantiates hfts_front, hfts_fifo and hfts_back; uses hfts_pkg and assert_macros.svh.
//
// The block holds a MAP_DIM x MAP_DIM grid of signed heights in one memory
// with a single read port. A load item writes one entry in a single step of
// the back; a query item reads its three corner heights one after another
// through that read port. The back takes loads at one per cycle while no
// result waits stalled at the output. The front takes items at one per cycle,
// while it does not stall, into a four-entry queue, so input items keep
// flowing while a result waits at the output register, until the queue and
// the input register are full. The height memory is not cleared after reset:
// a query that touches an entry never loaded returns an undefined height.
// Write the configuration registers only while no item is in flight.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module heightfield_triangle_sample (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  hfts_pkg::hfts_req_type              req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output hfts_pkg::hfts_rsp_type              rsp_data,
   input  logic                                csr_we,
   input  logic [hfts_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [hfts_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import hfts_pkg::*;

   logic           q_push;
   logic           q_pop;
   hfts_job_type   q_in;
   hfts_job_type   q_head;
   hfts_qstat_type q_stat;

   // Accept, scale and classify items.
   hfts_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .job_push  (q_push),
      .job_data  (q_in),
      .qstat     (q_stat)
   );

   // Decouple the front from the memory sequencer.
   hfts_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .pop       (q_pop),
      .head      (q_head),
      .qstat     (q_stat)
   );

   // Read corners, interpolate and present results.
   hfts_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (q_head),
      .qstat     (q_stat),
      .job_pop   (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Queue bookkeeping between the front and the back.
   `ASSERT_IMP(a_queue_no_overflow, clock, reset, q_push, !q_stat.full, "item pushed into a full queue")
   `ASSERT_IMP(a_queue_no_underflow, clock, reset, q_pop, q_stat.valid, "item popped from an empty queue")
   `ASSERT_NXT(a_queue_empty_holds, clock, reset, (!q_stat.valid && !q_push), !q_stat.valid, "queue filled without a push")

endmodule

`default_nettype wire

/* bench/tb_top.sv */
// Self-checking testbench for heightfield_triangle_sample: loads terrain heights, samples
// them at world positions and checks every height against a built-in predictor.
// Depends on hfts_pkg and the heightfield_triangle_sample RTL only.
`timescale 1ns / 1ps

module tb_top;
   import hfts_pkg::*;

   localparam int CYCLE_LIMIT  = 400_000;
   localparam int DRAIN_CYCLES = 24;
   localparam int PHASE_ITEMS  = 160;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   hfts_req_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   hfts_rsp_type rsp_data;
   logic                      csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   // Predictor state: configuration, terrain copy and which entries hold a height.
   logic [SIZE_BITS-1:0]  cfg_map_size = MAP_SIZE_RESET;
   logic [RECIP_BITS-1:0] cfg_grid_recip = GRID_RECIP_RESET;
   int                    terrain_mem [MEM_DEPTH];
   bit                    terrain_set [MEM_DEPTH];
   hfts_rsp_type          heights_due [$];

   int cycle_count = 0;
   int error_count = 0;
   int items_sent = 0;
   bit idle_en = 1'b1;

   heightfield_triangle_sample uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Stop a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout: run stopped after %0d cycles", cycle_count);
         $display("** heightfield_triangle_sample: FAILED **");
         $finish;
      end
   end

   // The result side stalls at random while idling is enabled.
   always @(posedge clock) begin
      rsp_stall <= idle_en && ($urandom_range(99) < 12);
   end

   task automatic report_mismatch(input string what);
      if (error_count < 40) $display("mismatch at cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   // Map size in use, saturated to the grid.
   function automatic int active_size();
      int size;
      size = cfg_map_size;
      if (size < 2) size = 2;
      else if (size > MAP_DIM) size = MAP_DIM;
      return size;
   endfunction

   // Scale one coordinate to grid units; the grid index truncates toward zero and is
   // clamped, the signed fraction is kept as it is.
   function automatic void split_axis(input logic signed [QPOS_BITS-1:0] pos, input int limit,
                                      output int grid_idx, output int frac);
      longint mag;
      longint scaled;
      mag = (pos < 0) ? -longint'(pos) : longint'(pos);
      scaled = (mag * longint'(cfg_grid_recip)) >> FRAC_BITS;
      grid_idx = int'(scaled >> FRAC_BITS);
      frac = int'(scaled & ((longint'(1) << FRAC_BITS) - 1));
      if (pos < 0) begin
         grid_idx = -grid_idx;
         frac = -frac;
      end
      if (grid_idx < 0) grid_idx = 0;
      else if (grid_idx > limit) grid_idx = limit;
   endfunction

   // Addresses of the three corners a query reads: nw, se and ne or sw.
   function automatic void find_corners(input logic signed [QPOS_BITS-1:0] qx, qz,
                                        output int nw_a, se_a, alt_a, xf, zf,
                                        output bit use_ne);
      int xi;
      int zi;
      split_axis(qx, active_size() - 2, xi, xf);
      split_axis(qz, active_size() - 2, zi, zf);
      use_ne = (zf <= xf);
      nw_a = zi * MAP_DIM + xi;
      se_a = nw_a + MAP_DIM + 1;
      alt_a = use_ne ? nw_a + 1 : nw_a + MAP_DIM;
   endfunction

   // Expected height of one query from the current terrain and configuration.
   function automatic hfts_rsp_type sample_height(input logic signed [QPOS_BITS-1:0] qx, qz);
      int nw_a, se_a, alt_a, xf, zf;
      bit use_ne;
      longint nw, se, ne, sw, top, bottom, level;
      hfts_rsp_type result;
      find_corners(qx, qz, nw_a, se_a, alt_a, xf, zf, use_ne);
      nw = terrain_mem[nw_a];
      se = terrain_mem[se_a];
      if (use_ne) begin
         ne = terrain_mem[alt_a];
         sw = nw + se - ne;
      end else begin
         sw = terrain_mem[alt_a];
         ne = nw + se - sw;
      end
      top = (nw <<< FRAC_BITS) + (ne - nw) * xf;
      bottom = (sw <<< FRAC_BITS) + (se - sw) * xf;
      level = (top <<< FRAC_BITS) + (bottom - top) * zf;
      level = (level + ROUND_ADD) >>> ROUND_SHIFT;
      result.saturated = 1'b0;
      if (level > longint'(OUT_MAX)) begin
         level = longint'(OUT_MAX);
         result.saturated = 1'b1;
      end else if (level < longint'(OUT_MIN)) begin
         level = longint'(OUT_MIN);
         result.saturated = 1'b1;
      end
      result.height_out = level[OUT_BITS-1:0];
      return result;
   endfunction

   // Heights lean toward the extremes of the field.
   function automatic logic signed [LOAD_H_BITS-1:0] pick_height();
      case ($urandom_range(7))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return LOAD_H_BITS'($urandom_range(127)) - 16'sd64;
         default: return LOAD_H_BITS'($urandom);
      endcase
   endfunction

   // Mostly positions on the map or just past its edges, some anywhere.
   function automatic logic signed [QPOS_BITS-1:0] pick_position();
      longint span;
      if (cfg_grid_recip == 0) span = longint'(1) << 22;
      else span = (longint'(active_size() - 1) << (2 * FRAC_BITS)) / longint'(cfg_grid_recip);
      if (span > (longint'(1) << 22)) span = longint'(1) << 22;
      case ($urandom_range(9))
         0, 1: return QPOS_BITS'($urandom);
         2: begin
            case ($urandom_range(3))
               0: return 24'sh7FFFFF;
               1: return 24'sh800000;
               2: return '0;
               default: return '1;
            endcase
         end
         default: return QPOS_BITS'(longint'($urandom_range(int'(span + span / 8))) - span / 16);
      endcase
   endfunction

   // Unused fields of an item carry noise.
   function automatic hfts_req_type make_load(input int col, input int row,
                                              input logic signed [LOAD_H_BITS-1:0] height);
      hfts_req_type item;
      item.kind = KIND_LOAD;
      item.load_col = COORD_BITS'(col);
      item.load_row = COORD_BITS'(row);
      item.load_height = height;
      item.query_x = QPOS_BITS'($urandom);
      item.query_z = QPOS_BITS'($urandom);
      return item;
   endfunction

   function automatic hfts_req_type make_query(input logic signed [QPOS_BITS-1:0] qx, qz);
      hfts_req_type item;
      item.kind = KIND_QUERY;
      item.load_col = COORD_BITS'($urandom);
      item.load_row = COORD_BITS'($urandom);
      item.load_height = LOAD_H_BITS'($urandom);
      item.query_x = qx;
      item.query_z = qz;
      return item;
   endfunction

   // Offer one item, hold it until accepted, then update the predictor.
   task automatic send_item(input hfts_req_type item);
      int addr;
      int level;
      while (idle_en && $urandom_range(99) < 12) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(negedge clock);
      while (req_stall !== 1'b0) @(negedge clock);
      @(posedge clock);
      if (item.kind == KIND_LOAD) begin
         if (int'(item.load_col) < MAP_DIM && int'(item.load_row) < MAP_DIM) begin
            addr = int'(item.load_row) * MAP_DIM + int'(item.load_col);
            level = int'(item.load_height);
            level = (level <<< (32 - HEIGHT_BITS)) >>> (32 - HEIGHT_BITS);
            terrain_mem[addr] = level;
            terrain_set[addr] = 1'b1;
         end
      end else begin
         heights_due.push_back(sample_height(item.query_x, item.query_z));
      end
      items_sent++;
   endtask

   // A query is preceded by loads of any corner it reads that holds no height yet.
   task automatic send_query(input logic signed [QPOS_BITS-1:0] qx, qz);
      int corner [3];
      int xf;
      int zf;
      bit use_ne;
      find_corners(qx, qz, corner[0], corner[1], corner[2], xf, zf, use_ne);
      foreach (corner[i]) begin
         if (!terrain_set[corner[i]])
            send_item(make_load(corner[i] % MAP_DIM, corner[i] / MAP_DIM, pick_height()));
      end
      send_item(make_query(qx, qz));
   endtask

   // Stop sending and let every outstanding item, including loads, finish.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (heights_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_config(input int size_value, input int recip_value);
      wait_idle();
      csr_we <= 1'b1;
      csr_index <= CSR_MAP_SIZE;
      csr_wdata <= CSR_DATA_BITS'(size_value);
      @(posedge clock);
      csr_index <= CSR_GRID_RECIP;
      csr_wdata <= CSR_DATA_BITS'(recip_value);
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_map_size = SIZE_BITS'(size_value);
      cfg_grid_recip = RECIP_BITS'(recip_value);
   endtask

   // Compare each accepted result with the oldest expected height.
   always @(negedge clock) begin : check_heights
      hfts_rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (heights_due.size() == 0) begin
            report_mismatch($sformatf("result %h with no query waiting", rsp_data));
         end else begin
            want = heights_due.pop_front();
            if (rsp_data.height_out !== want.height_out)
               report_mismatch($sformatf("height_out %h, expected %h",
                                         rsp_data.height_out, want.height_out));
            if (rsp_data.saturated !== want.saturated)
               report_mismatch($sformatf("saturated %b, expected %b",
                                         rsp_data.saturated, want.saturated));
         end
      end
   end

   // Reset configuration: triangles, exact grid points, edges and saturation.
   task automatic test_directed_grid();
      send_item(make_load(0, 0, 16'sh7FFF));
      send_item(make_load(1, 0, 16'sh8000));
      send_item(make_load(0, 1, 16'sh8000));
      send_item(make_load(1, 1, 16'sh7FFF));
      send_query(24'sd0, 24'sd0);
      send_query(24'sh80, 24'sh40);
      send_query(24'sh40, 24'sh80);
      send_query(24'sh80, 24'sh80);
      send_query(-24'sd255, 24'sd0);
      send_query(24'sd0, -24'sd255);
      send_query(-24'sd128, 24'sh7F);
      send_item(make_load(255, 255, 16'sh8000));
      send_query(24'sh7FFFFF, 24'sh7FFFFF);
      send_query(24'sh800000, 24'sh800000);
      send_query(24'sh7FFFFF, 24'sh800000);
      send_item(make_load(0, 0, -16'sd1));
      send_query(24'sh10, 24'sh01);
   endtask

   // Register extremes: size below, at and above its range, zero and full reciprocal.
   task automatic test_config_extremes();
      write_config(0, 0);
      repeat (4) send_query(QPOS_BITS'($urandom), QPOS_BITS'($urandom));
      write_config(1, 24'hFFFFFF);
      send_item(make_load(0, 1, 16'sh7FFF));
      send_item(make_load(1, 0, 16'sh8000));
      repeat (6) send_query(QPOS_BITS'($urandom), QPOS_BITS'($urandom));
      write_config(511, 1);
      repeat (4) send_query(QPOS_BITS'($urandom), QPOS_BITS'($urandom));
      write_config(256, 24'hFFFFFF);
      repeat (4) send_query(QPOS_BITS'($urandom), QPOS_BITS'($urandom));
   endtask

   // One random configuration, then queries with their corner loads and stray loads.
   task automatic run_random_phase(input int item_goal);
      int stop_at;
      int roll;
      int size_value;
      int recip_value;
      case ($urandom_range(4))
         0: size_value = 2;
         1: size_value = $urandom_range(3, 16);
         2: size_value = 256;
         3: size_value = $urandom_range(17, 255);
         default: size_value = $urandom_range(257, 511);
      endcase
      case ($urandom_range(3))
         0: recip_value = 65536;
         1: recip_value = $urandom_range(1, 16777215);
         2: recip_value = $urandom_range(4096, 262144);
         default: recip_value = $urandom_range(1) ? 16777215 : 1;
      endcase
      write_config(size_value, recip_value);
      stop_at = items_sent + item_goal;
      while (items_sent < stop_at) begin
         roll = $urandom_range(99);
         if (roll < 2)
            wait_idle();
         else if (roll < 60)
            send_query(pick_position(), pick_position());
         else if (roll < 85)
            send_item(make_load($urandom_range(active_size() - 1),
                                $urandom_range(active_size() - 1), pick_height()));
         else
            send_item(make_load($urandom, $urandom, pick_height()));
      end
   endtask

   task automatic test_random_traffic();
      repeat (4) run_random_phase(PHASE_ITEMS);
   endtask

   // Back-to-back items with no idling on either side.
   task automatic test_steady_stream();
      idle_en = 1'b0;
      repeat (2) run_random_phase(PHASE_ITEMS);
      idle_en = 1'b1;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_grid();
      test_config_extremes();
      test_random_traffic();
      test_steady_stream();
      wait_idle();
      if (error_count == 0) begin
         $display("** heightfield_triangle_sample: PASSED **");
      end else begin
         $display("** heightfield_triangle_sample: FAILED **");
      end
      $finish;
   end

endmodule
